// ===== src/mant_pkg.sv =====
// Shared types and constants for the MIDI active note tracker.
`default_nettype none

package mant_pkg;

    // Field widths of a note event
    localparam int CH_W    = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int TDATA_W = 24;

    // Input action codes carried on s_tuser
    typedef enum logic [1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_ALL_OFF  = 2'd2
    } action_t;

    // Output message kinds carried on m_tuser
    typedef enum logic {
        KIND_ON  = 1'b0,
        KIND_OFF = 1'b1
    } kind_t;

    // One slot of the note table
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [NOTE_W-1:0] note;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/mant_slot_mem.sv =====
// Slot table memory: channel and note per slot, one write and one registered read port.
`default_nettype none

module mant_slot_mem
    import mant_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire entry_t           wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output entry_t                rdata
);

    entry_t mem_array [SLOTS];
    entry_t rdata_reg;

    // Write and synchronous read; read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/mant_ctrl.sv =====
// Slot walk sequencer: valid bits, read-modify-write of the slot table, output word register.
`default_nettype none

module mant_ctrl
    import mant_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // channel[3:0], note[10:4], velocity[17:11]
    input  wire logic [1:0]         s_tuser,   // action[1:0]
    // output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // out_channel[3:0], out_note[10:4], out_velocity[17:11]
    output logic [0:0]              m_tuser,   // msg_kind[0]
    output logic                    m_tlast,   // last
    // slot memory
    output logic                    mem_we,
    output logic [IDX_W-1:0]        mem_waddr,
    output entry_t                  mem_wdata,
    output logic [IDX_W-1:0]        mem_raddr,
    input  wire entry_t             mem_rdata
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    action_t            act_reg, act_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [NOTE_W-1:0]  note_reg, note_next;
    logic [VEL_W-1:0]   vel_reg, vel_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;

    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, m_kind_next;
    logic [CH_W-1:0]    m_ch_reg, m_ch_next;
    logic [NOTE_W-1:0]  m_note_reg, m_note_next;
    logic [VEL_W-1:0]   m_vel_reg, m_vel_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic               at_end;
    logic               cur_valid;
    logic               others_valid;
    logic               match;
    logic [IDX_W-1:0]   target;

    // Slot under the walk and what remains valid beside it
    assign out_free     = !m_valid_reg || m_tready;
    assign at_end       = (idx_reg == IDX_W'(SLOTS - 1));
    assign cur_valid    = valid_reg[idx_reg];
    assign others_valid = |(valid_reg & ~(SLOTS'(1) << idx_reg));
    assign match        = cur_valid && (mem_rdata.channel == ch_reg)
                          && (mem_rdata.note == note_reg);
    assign target       = cur_valid ? '0 : idx_reg;

    // Next state: one slot visited per cycle, held while the output word waits
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        act_next     = act_reg;
        ch_next      = ch_reg;
        note_next    = note_reg;
        vel_next     = vel_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_ch_next    = m_ch_reg;
        m_note_next  = m_note_reg;
        m_vel_next   = m_vel_reg;
        m_last_next  = m_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = target;
        mem_wdata    = '{channel: ch_reg, note: note_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ch_next   = s_tdata[3:0];
                    note_next = s_tdata[10:4];
                    vel_next  = s_tdata[17:11];
                    idx_next  = '0;
                    unique case (s_tuser)
                        ACT_NOTE_ON, ACT_NOTE_OFF, ACT_ALL_OFF:
                        begin
                            act_next   = action_t'(s_tuser);
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (out_free)
                begin
                    unique case (act_reg)
                        ACT_NOTE_ON:
                        begin
                            // first free slot, or slot 0 when the table is full
                            if (!cur_valid || at_end)
                            begin
                                mem_we             = 1'b1;
                                valid_next[target] = 1'b1;
                                m_valid_next       = 1'b1;
                                m_kind_next        = KIND_ON;
                                m_ch_next          = ch_reg;
                                m_note_next        = note_reg;
                                m_vel_next         = vel_reg;
                                m_last_next        = 1'b1;
                                state_next         = ST_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end

                        ACT_NOTE_OFF:
                        begin
                            // free the first matching slot; the word goes out either way
                            if (match)
                            begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            if (match || at_end)
                            begin
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_OFF;
                                m_ch_next    = ch_reg;
                                m_note_next  = note_reg;
                                m_vel_next   = vel_reg;
                                m_last_next  = 1'b1;
                                state_next   = ST_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end

                        default:
                        begin
                            // all notes off: one word per valid slot, last when none remain
                            if (cur_valid)
                            begin
                                valid_next[idx_reg] = 1'b0;
                                m_valid_next        = 1'b1;
                                m_kind_next         = KIND_OFF;
                                m_ch_next           = mem_rdata.channel;
                                m_note_next         = mem_rdata.note;
                                m_vel_next          = '0;
                                m_last_next         = !others_valid;
                            end
                            if (at_end)
                            begin
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, valid bits and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            act_reg     <= ACT_NOTE_ON;
            ch_reg      <= '0;
            note_reg    <= '0;
            vel_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_kind_reg  <= KIND_ON;
            m_ch_reg    <= '0;
            m_note_reg  <= '0;
            m_vel_reg   <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            act_reg     <= act_next;
            ch_reg      <= ch_next;
            note_reg    <= note_next;
            vel_reg     <= vel_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            m_kind_reg  <= m_kind_next;
            m_ch_reg    <= m_ch_next;
            m_note_reg  <= m_note_next;
            m_vel_reg   <= m_vel_next;
            m_last_reg  <= m_last_next;
        end
    end

    // Read runs one slot ahead so data for idx_reg is ready each cycle
    assign mem_raddr = idx_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - CH_W - NOTE_W - VEL_W){1'b0}}, m_vel_reg, m_note_reg, m_ch_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== src/midi_active_note_tracker_core.sv =====
// Top level of the MIDI active note tracker: slot memory plus walk sequencer.
// Flow: the input word is taken, then the walk visits one slot per cycle while the output is free;
//   a result word is registered and appears the cycle after the slot that decides it.
// Input: a new word is taken only in idle, once the slot walk for the last one is over; the walk
//   reads one entry at a time over the memory read port and waits while m_tready holds the output.
// Reset: clears all slot valid bits and the output word; table contents are not cleared.
`default_nettype none

module midi_active_note_tracker_core
    import mant_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // channel[3:0], note[10:4], velocity[17:11]
    input  wire logic [1:0]         s_tuser,   // action[1:0]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // out_channel[3:0], out_note[10:4], out_velocity[17:11]
    output logic [0:0]              m_tuser,   // msg_kind[0]
    output logic                    m_tlast    // last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;

    mant_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mant_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Table writes happen only inside a walk, never while a word is being taken
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !s_tready)
        else $error("slot write while input ready");

    // A table write always comes with a note-on word
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (m_tvalid && (m_tuser == KIND_ON) && m_tlast))
        else $error("slot write without note-on word");

    // A valid action starts a walk and drops ready
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser <= ACT_ALL_OFF)) |=> !s_tready)
        else $error("ready held after accepting an action");

endmodule

`default_nettype wire

// ===== dv/note_msg_checker.sv =====
// Checker for the active note tracker: predicts emitted note messages and compares them.
module note_msg_checker
    import mant_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // channel[3:0], note[10:4], velocity[17:11]
    input  wire logic [1:0]         s_tuser,   // action[1:0]
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,   // out_channel[3:0], out_note[10:4], out_velocity[17:11]
    input  wire logic [0:0]         m_tuser,   // msg_kind[0]
    input  wire logic               m_tlast,
    output int                      mismatches,
    output int                      msgs_due
);

    localparam int NOTE_LSB = CH_W;
    localparam int VEL_LSB  = CH_W + NOTE_W;
    localparam int PAD_LSB  = CH_W + NOTE_W + VEL_W;

    // One outgoing note message
    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   channel;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              last;
    } note_msg_t;

    // Shadow of the note table
    logic      slot_used [SLOTS];
    entry_t    slot_tab  [SLOTS];
    note_msg_t due_msgs  [$];

    task automatic flag_error(input string detail);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $time, detail);
    endtask

    // Update the note table for one accepted event and queue the messages it causes
    task automatic track_event(
        input logic [1:0]        act,
        input logic [CH_W-1:0]   ch,
        input logic [NOTE_W-1:0] nt,
        input logic [VEL_W-1:0]  vel
    );
        int        target;
        int        hit;
        int        final_slot;
        note_msg_t msg;
        target     = 0;
        hit        = -1;
        final_slot = -1;
        case (act)
            ACT_NOTE_ON:
            begin
                // lowest free slot, slot 0 when the table is full
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i])
                        target = i;
                slot_used[target]       = 1'b1;
                slot_tab[target].channel = ch;
                slot_tab[target].note    = nt;
                msg.kind     = KIND_ON;
                msg.channel  = ch;
                msg.note     = nt;
                msg.velocity = vel;
                msg.last     = 1'b1;
                due_msgs.push_back(msg);
            end
            ACT_NOTE_OFF:
            begin
                // free the lowest matching slot; the note-off goes out regardless
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_used[i] && slot_tab[i].channel == ch && slot_tab[i].note == nt)
                        hit = i;
                if (hit >= 0)
                    slot_used[hit] = 1'b0;
                msg.kind     = KIND_OFF;
                msg.channel  = ch;
                msg.note     = nt;
                msg.velocity = vel;
                msg.last     = 1'b1;
                due_msgs.push_back(msg);
            end
            ACT_ALL_OFF:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i])
                        final_slot = i;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        msg.kind     = KIND_OFF;
                        msg.channel  = slot_tab[i].channel;
                        msg.note     = slot_tab[i].note;
                        msg.velocity = '0;
                        msg.last     = (i == final_slot);
                        due_msgs.push_back(msg);
                        slot_used[i] = 1'b0;
                    end
                end
            end
            default:
            begin
                // unused action code: nothing happens
            end
        endcase
    endtask

    // Compare one emitted word with the oldest expected message
    task automatic check_msg();
        note_msg_t want;
        string     got_str;
        got_str = $sformatf("kind=%0d ch=%0d note=%0d vel=%0d last=%0d pad=%0h",
                            m_tuser[0], m_tdata[NOTE_LSB-1:0], m_tdata[VEL_LSB-1:NOTE_LSB],
                            m_tdata[PAD_LSB-1:VEL_LSB], m_tlast, m_tdata[TDATA_W-1:PAD_LSB]);
        if (due_msgs.size() == 0)
        begin
            flag_error({"unexpected word: ", got_str});
        end
        else
        begin
            want = due_msgs.pop_front();
            if (m_tuser[0] !== want.kind
                || m_tdata[NOTE_LSB-1:0] !== want.channel
                || m_tdata[VEL_LSB-1:NOTE_LSB] !== want.note
                || m_tdata[PAD_LSB-1:VEL_LSB] !== want.velocity
                || m_tlast !== want.last
                || m_tdata[TDATA_W-1:PAD_LSB] !== '0)
                flag_error($sformatf("expected kind=%0d ch=%0d note=%0d vel=%0d last=%0d pad=0, got %s",
                                     want.kind, want.channel, want.note, want.velocity,
                                     want.last, got_str));
        end
    endtask

    // Outputs first: a word leaving at this edge never stems from the word taken at it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            due_msgs.delete();
            mismatches = 0;
            msgs_due <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_msg();
            if (s_tvalid && s_tready)
                track_event(s_tuser, s_tdata[NOTE_LSB-1:0], s_tdata[VEL_LSB-1:NOTE_LSB],
                            s_tdata[PAD_LSB-1:VEL_LSB]);
            msgs_due <= due_msgs.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the active note tracker: clock, reset, stimulus, flow control and verdict.
module tb;
    import mant_pkg::*;

    localparam int SLOTS          = 16;
    localparam int STALL_LIMIT    = 2000;   // idle cycles before the run is called hung
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off in the last phase
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               m_tlast;

    int     mismatches;
    int     msgs_due;
    int     tx_idle     = 0;
    int     rx_idle     = 0;
    int     items_sent  = 0;
    int     quiet_count = 0;
    int     hold_count  = 0;
    logic   hold_req    = 1'b0;
    entry_t held_notes [$];

    midi_active_note_tracker_core #(.SLOTS(SLOTS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    note_msg_checker #(.SLOTS(SLOTS)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .msgs_due   (msgs_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one word and wait until it is taken
    task automatic send_word(
        input logic [1:0]        act,
        input logic [CH_W-1:0]   ch,
        input logic [NOTE_W-1:0] nt,
        input logic [VEL_W-1:0]  vel
    );
        while (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(TDATA_W - CH_W - NOTE_W - VEL_W){1'b0}}, vel, nt, ch};
        do
            @(posedge clk);
        while (!s_tready);
        if (act != ACT_RESERVED)
            items_sent++;
    endtask

    // One random event, mostly note-ons, with note-offs that usually hit a sounding note
    task automatic random_event();
        int     pick;
        int     idx;
        int     burst;
        entry_t held;
        pick = int'($urandom_range(99));
        if (pick < 3)
        begin
            // burst of note-ons that can overflow the table
            burst = int'($urandom_range(SLOTS + 4, SLOTS - 2));
            for (int i = 0; i < burst; i++)
            begin
                held.channel = CH_W'($urandom_range(15));
                held.note    = NOTE_W'($urandom_range(127));
                held_notes.push_back(held);
                send_word(ACT_NOTE_ON, held.channel, held.note, VEL_W'($urandom_range(127)));
            end
        end
        else if (pick < 45)
        begin
            held.channel = CH_W'($urandom_range(15));
            held.note    = NOTE_W'($urandom_range(127));
            held_notes.push_back(held);
            send_word(ACT_NOTE_ON, held.channel, held.note, VEL_W'($urandom_range(127)));
        end
        else if (pick < 80)
        begin
            if (held_notes.size() > 0 && $urandom_range(9) < 7)
            begin
                idx  = int'($urandom_range(held_notes.size() - 1));
                held = held_notes[idx];
                held_notes.delete(idx);
                send_word(ACT_NOTE_OFF, held.channel, held.note, VEL_W'($urandom_range(127)));
            end
            else
                send_word(ACT_NOTE_OFF, CH_W'($urandom_range(15)),
                          NOTE_W'($urandom_range(127)), VEL_W'($urandom_range(127)));
        end
        else if (pick < 93)
        begin
            held_notes.delete();
            send_word(ACT_ALL_OFF, CH_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
                      VEL_W'($urandom_range(127)));
        end
        else
            send_word(ACT_RESERVED, CH_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
                      VEL_W'($urandom_range(127)));
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, duplicates, unmatched note-off, reserved code, empty all-off
        tx_idle = 37;
        rx_idle = 65;
        send_word(ACT_NOTE_ON, 4'd0, 7'd0, 7'd0);
        send_word(ACT_NOTE_ON, 4'd15, 7'd127, 7'd127);
        send_word(ACT_NOTE_ON, 4'd15, 7'd127, 7'd1);
        send_word(ACT_NOTE_OFF, 4'd15, 7'd127, 7'd127);
        send_word(ACT_NOTE_OFF, 4'd3, 7'd64, 7'd5);
        send_word(ACT_RESERVED, 4'd15, 7'd127, 7'd127);
        send_word(ACT_ALL_OFF, 4'd9, 7'd33, 7'd100);
        send_word(ACT_ALL_OFF, 4'd15, 7'd127, 7'd127);
        // fill the table and one more: the last note-on lands in slot 0
        for (int i = 0; i <= SLOTS; i++)
            send_word(ACT_NOTE_ON, i[3:0], 7'(i * 7 + 3), 7'(127 - i));
        send_word(ACT_ALL_OFF, 4'd0, 7'd0, 7'd0);

        // random, sender idles less than receiver
        while (items_sent < 45)
            random_event();

        // random, roles swapped
        tx_idle = 65;
        rx_idle = 37;
        while (items_sent < 70)
            random_event();

        // random, no idling, starting under a long receiver hold-off
        tx_idle  = 0;
        rx_idle  = 0;
        hold_req <= 1'b1;
        while (items_sent < 95)
            random_event();
        s_tvalid <= 1'b0;

        // drain, then a quiet tail long enough for any stray word
        @(posedge clk);
        while (msgs_due != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 8) @(posedge clk);

        if (mismatches == 0 && msgs_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mant_pkg.sv
src/mant_slot_mem.sv
src/mant_ctrl.sv
src/midi_active_note_tracker_core.sv
dv/note_msg_checker.sv
dv/tb.sv
